// ===== sv/breakpoint_match_unit_defines.svh =====
// Assertion macros shared by the breakpoint match unit RTL.
`ifndef BREAKPOINT_MATCH_UNIT_DEFINES_SVH
`define BREAKPOINT_MATCH_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BPM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpm assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define BPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpm assertion failed: next-cycle implication");

`endif

// ===== sv/bpm_pkg.sv =====
// Types and constants shared by the breakpoint match unit modules.
`default_nettype none

package bpm_pkg;

  // Request kind codes
  localparam logic [1:0] KIND_CHECK = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // Bus source with the WRAM mirror rule
  localparam logic [2:0] SRC_CPU_BUS = 3'd0;

  // WRAM mirror windows, applied to the stored entry address
  localparam logic [23:0] MIRROR_A_MASK  = 24'h40e000;
  localparam logic [23:0] MIRROR_A_VALUE = 24'h000000;
  localparam logic [23:0] MIRROR_B_MASK  = 24'hffe000;
  localparam logic [23:0] MIRROR_B_VALUE = 24'h7e0000;
  localparam int          MIRROR_BITS    = 13;

  // Operation after classification
  typedef enum logic [1:0] {
    OP_CHECK,
    OP_LOAD,
    OP_QUERY,
    OP_NONE
  } op_t;

  // Request transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  access_source;
    logic [1:0]  access_mode;
    logic [23:0] address;
    logic [7:0]  data_byte;
    logic [2:0]  entry_index;
    logic        entry_enable;
    logic        match_any_data;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic        hit;
    logic [2:0]  hit_index;
    logic [31:0] hit_count;
  } rsp_t;

  // Classified item held in the queue
  typedef struct packed {
    op_t         op;
    logic        idx_ok;
    logic [2:0]  access_source;
    logic [1:0]  access_mode;
    logic [23:0] address;
    logic [7:0]  data_byte;
    logic [2:0]  entry_index;
    logic        entry_enable;
    logic        match_any_data;
  } item_t;

  // Queue status seen by the front end
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ===== sv/bpm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and read-old registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/bpm_front.sv =====
// Front end: accepts request transactions and classifies them for the queue.
`default_nettype none

module bpm_front import bpm_pkg::*; #(
  parameter int NUM_BREAKPOINTS = 8
) (
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire req_t      req,
  input  wire q_status_t q_status,
  output logic           push,
  output item_t          push_item
);

  // Room in the queue is the only condition for taking a transaction
  assign req_ready = !q_status.full;
  assign push      = req_valid && req_ready;

  // Decode kind; the spare code behaves as a no-op
  always_comb begin
    push_item = '0;
    unique case (req.kind)
      KIND_CHECK: push_item.op = OP_CHECK;
      KIND_LOAD:  push_item.op = OP_LOAD;
      KIND_QUERY: push_item.op = OP_QUERY;
      default:    push_item.op = OP_NONE;
    endcase
    push_item.idx_ok         = int'(req.entry_index) < NUM_BREAKPOINTS;
    push_item.access_source  = req.access_source;
    push_item.access_mode    = req.access_mode;
    push_item.address        = req.address;
    push_item.data_byte      = req.data_byte;
    push_item.entry_index    = req.entry_index;
    push_item.entry_enable   = req.entry_enable;
    push_item.match_any_data = req.match_any_data;
  end

endmodule

`default_nettype wire

// ===== sv/bpm_queue.sv =====
// Short FIFO of classified items between the front and back ends.
`default_nettype none

`include "breakpoint_match_unit_defines.svh"

module bpm_queue import bpm_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      pop_item,
  output q_status_t  status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign pop_item     = slots[rptr];

  // Storage writes
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `BPM_ASSERT_IMPLIES(a_no_push_when_full, clk, rst, push, count != CW'(DEPTH))
  `BPM_ASSERT_IMPLIES(a_no_pop_when_empty, clk, rst, pop, count != '0)

endmodule

`default_nettype wire

// ===== sv/bpm_back.sv =====
// Back end: entry table, comparator bank, hit counters and response register.
`default_nettype none

`include "breakpoint_match_unit_defines.svh"

module bpm_back import bpm_pkg::*; #(
  parameter int NUM_BREAKPOINTS = 8
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  input  wire item_t q_item,
  output logic       q_pop,
  output logic       rsp_valid,
  input  wire logic  rsp_ready,
  output rsp_t       rsp
);

  localparam int IW = (NUM_BREAKPOINTS > 1) ? $clog2(NUM_BREAKPOINTS) : 1;

  // Entry table
  logic        ent_en   [NUM_BREAKPOINTS];
  logic [23:0] ent_addr [NUM_BREAKPOINTS];
  logic [7:0]  ent_data [NUM_BREAKPOINTS];
  logic        ent_any  [NUM_BREAKPOINTS];
  logic [2:0]  ent_src  [NUM_BREAKPOINTS];
  logic [1:0]  ent_mode [NUM_BREAKPOINTS];

  // Counter valid bits; an entry not yet written reads as zero
  logic [NUM_BREAKPOINTS-1:0] cnt_valid;

  logic [2:0] last_hit;

  // Match stage registers
  logic          a_valid;
  op_t           a_op;
  logic          a_hit;
  logic          a_idx_ok;
  logic [IW-1:0] a_idx;
  logic [2:0]    a_report;

  // Counter read path
  logic [IW-1:0] raddr;
  logic [31:0]   ram_q;
  logic          rvalid;
  logic          fwd;
  logic [31:0]   fwd_data;

  logic [NUM_BREAKPOINTS-1:0] match;
  logic [IW-1:0] sel;
  logic          any_match;
  logic [IW+2:0] idx_wide;
  logic [IW+2:0] sel_wide;
  logic [IW-1:0] idx_addr;
  logic [IW-1:0] new_idx;
  logic [2:0]    report;
  logic          is_load;
  logic          a_adv;
  logic          a_wr;
  logic [31:0]   cur;
  logic [31:0]   cur_inc;
  logic [31:0]   a_wdata;
  logic [31:0]   rsp_count;

  // Comparator per entry
  always_comb begin
    for (int i = 0; i < NUM_BREAKPOINTS; i++) begin
      logic mirrored;
      logic addr_ok;
      mirrored = (q_item.access_source == SRC_CPU_BUS) &&
                 (((ent_addr[i] & MIRROR_A_MASK) == MIRROR_A_VALUE) ||
                  ((ent_addr[i] & MIRROR_B_MASK) == MIRROR_B_VALUE));
      addr_ok  = mirrored ?
                 (ent_addr[i][MIRROR_BITS-1:0] == q_item.address[MIRROR_BITS-1:0]) :
                 (ent_addr[i] == q_item.address);
      match[i] = ent_en[i] && addr_ok &&
                 (ent_any[i] || (ent_data[i] == q_item.data_byte)) &&
                 (ent_src[i] == q_item.access_source) &&
                 (ent_mode[i] == q_item.access_mode);
    end
  end

  // Lowest matching entry wins
  always_comb begin
    sel = '0;
    for (int i = NUM_BREAKPOINTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        sel = IW'(i);
      end
    end
  end

  assign any_match = (q_item.op == OP_CHECK) && (|match);
  assign idx_wide  = (IW + 3)'(q_item.entry_index);
  assign idx_addr  = idx_wide[IW-1:0];
  assign sel_wide  = (IW + 3)'(sel);
  assign new_idx   = (q_item.op == OP_CHECK) ? sel : idx_addr;
  assign report    = any_match ? sel_wide[2:0] : last_hit;
  assign is_load   = (q_item.op == OP_LOAD) && q_item.idx_ok;

  // Stage handshake: match stage drains into the response register
  assign a_adv = a_valid && (!rsp_valid || rsp_ready);
  assign q_pop = q_valid && (!a_valid || a_adv);

  // A stalled stage re-reads its own counter to keep the read data live
  assign raddr = q_pop ? new_idx : a_idx;

  // Counter update
  assign cur      = fwd ? fwd_data : (rvalid ? ram_q : '0);
  assign cur_inc  = cur + 32'd1;
  assign a_wr     = a_adv && (((a_op == OP_CHECK) && a_hit) ||
                              ((a_op == OP_LOAD) && a_idx_ok));
  assign a_wdata  = (a_op == OP_CHECK) ? cur_inc : '0;

  always_comb begin
    rsp_count = '0;
    if ((a_op == OP_CHECK) && a_hit) begin
      rsp_count = cur_inc;
    end else if ((a_op == OP_QUERY) && a_idx_ok) begin
      rsp_count = cur;
    end
  end

  bpm_ram #(
    .WIDTH (32),
    .DEPTH (NUM_BREAKPOINTS)
  ) u_counters (
    .clk   (clk),
    .we    (a_wr),
    .waddr (a_idx),
    .wdata (a_wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // Entry table payload
  always_ff @(posedge clk) begin
    if (q_pop && is_load) begin
      ent_addr[idx_addr] <= q_item.address;
      ent_data[idx_addr] <= q_item.data_byte;
      ent_any[idx_addr]  <= q_item.match_any_data;
      ent_src[idx_addr]  <= q_item.access_source;
      ent_mode[idx_addr] <= q_item.access_mode;
    end
  end

  // Match stage payload, counter read side and response payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_op     <= q_item.op;
      a_hit    <= any_match;
      a_idx_ok <= q_item.idx_ok;
      a_idx    <= new_idx;
      a_report <= report;
      fwd_data <= a_wdata;
    end
    rvalid <= cnt_valid[raddr];
    if (a_adv) begin
      rsp.hit       <= (a_op == OP_CHECK) && a_hit;
      rsp.hit_index <= a_report;
      rsp.hit_count <= rsp_count;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BREAKPOINTS; i++) begin
        ent_en[i] <= 1'b0;
      end
      cnt_valid <= '0;
      last_hit  <= '0;
      a_valid   <= 1'b0;
      fwd       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (q_pop && is_load) begin
        ent_en[idx_addr] <= q_item.entry_enable;
      end
      if (q_pop) begin
        last_hit <= report;
      end
      if (a_wr) begin
        cnt_valid[a_idx] <= 1'b1;
      end
      // Bypass a counter written at the same edge it is read
      fwd <= q_pop && a_wr && (a_idx == new_idx);
      if (q_pop) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
      if (a_adv) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `BPM_ASSERT_NEXT(a_fwd_follows_write, clk, rst, !(q_pop && a_wr), !fwd)
  `BPM_ASSERT_IMPLIES(a_hit_on_loaded_counter, clk, rst,
      a_adv && (a_op == OP_CHECK) && a_hit, cnt_valid[a_idx])

endmodule

`default_nettype wire

// ===== sv/breakpoint_match_unit.sv =====
// Breakpoint match unit: takes one request transaction per cycle while its queue has room
// and returns one response per request, in order. Throughput is one transaction per cycle,
// sustained while rsp_ready is held high; an accepted request passes through the queue
// slot written at acceptance, the comparator and counter read stage, and the response
// register. The per-cycle rate is set by the comparator bank with its lowest-index pick
// and by the hit-counter RAM, read for the match stage and written back as that stage
// advances, with a bypass for back-to-back hits on one entry. Counters are cleared at
// reset by per-entry valid bits, so no clearing pass is needed. Only entries 0 to 7 are
// reachable by entry_index.
`default_nettype none

module breakpoint_match_unit import bpm_pkg::*; #(
  parameter int NUM_BREAKPOINTS = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  q_status_t q_status;
  logic      push;
  item_t     push_item;
  logic      pop;
  item_t     pop_item;

  // Request classification
  bpm_front #(
    .NUM_BREAKPOINTS (NUM_BREAKPOINTS)
  ) u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  // Decoupling queue
  bpm_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  // Matching, counters and responses
  bpm_back #(
    .NUM_BREAKPOINTS (NUM_BREAKPOINTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (!q_status.empty),
    .q_item    (pop_item),
    .q_pop     (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
